>>> sv/mtq_pkg.sv
// ----------------------------------------------------------------------------
// mtq_pkg: shared types and constants of the multi timer queue
// operation, reply and status codes, input and output item types
// ----------------------------------------------------------------------------
package mtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int MAX_RESULTS    = 16;
    localparam int ID_BITS        = 32;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] RK_START = 2'd0;
    localparam logic [1:0] RK_STOP  = 2'd1;
    localparam logic [1:0] RK_FIRED = 2'd2;
    localparam logic [1:0] RK_QUERY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
        logic [31:0] target_id;
    } mtq_in_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] reply_id;
        logic [1:0]  status;
        logic        last_of_run;
    } mtq_out_t;

endpackage

>>> sv/multi_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_timer_queue_unit: table of software timers against a tick counter
// one shared compare unit walks the slot table under a small sequencer
// ----------------------------------------------------------------------------
// start replies straight from the idle state; stop and query reply after one full
// scan of the slot table and free the input once the reply is taken
// tick: a find-expired scan per fired timer, plus one final scan; a fired timer
// waits in the write-back state for the output to drain; a quiet tick runs one scan
// one item at a time; in_ready is low while an item is in work or a reply waits
// reset: rst_n clears tick count, id counter and all slot valid bits at once
module multi_timer_queue_unit #(
    parameter int NUM_TIMERS = mtq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = mtq_pkg::TIME_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mtq_pkg::mtq_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mtq_pkg::mtq_out_t out_data
);
    import mtq_pkg::*;

    localparam int SB = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CB = $clog2(NUM_TIMERS + 1);
    localparam int RW = ID_BITS + 2 * TIME_BITS;
    localparam int NB = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]           state_reg, state_next;
    mtq_in_t              item_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [ID_BITS-1:0]   nid_reg;
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] done_reg;   // fired in this tick
    logic [CB-1:0]        idx_reg;
    logic                 found_reg;
    logic [SB-1:0]        best_reg;
    logic [ID_BITS-1:0]   bid_reg;
    logic [TIME_BITS-1:0] bdl_reg;
    logic [TIME_BITS-1:0] bper_reg;
    logic [NB-1:0]        nfire_reg;
    logic                 pend_reg;     // fired item waiting for a later scan
    mtq_out_t             pout_reg;
    mtq_out_t             out_reg;
    logic                 ov_reg;

    // slot record ram
    logic                 ram_we;
    logic [SB-1:0]        ram_addr;
    logic [RW-1:0]        ram_wdata, ram_rdata;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_dl, r_per;

    mtq_ram #(.WIDTH(RW), .DEPTH(NUM_TIMERS)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign {r_id, r_dl, r_per} = ram_rdata;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    logic [SB-1:0]        cur;
    logic [TIME_BITS-1:0] d_exp, d_ord;
    logic                 cand, better;
    logic [SB-1:0]        free_slot;
    logic                 any_free;

    assign cur = idx_reg[SB-1:0];

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SB'(i);
                any_free  = 1'b1;
            end
        end
    end

    // shared compare unit
    always_comb
    begin
        d_exp = now_reg - r_dl;
        d_ord = r_dl - bdl_reg;
        cand = 1'b0;
        better = 1'b0;
        case (item_reg.opcode)
            OP_TICK:
            begin
                cand = valid_reg[cur] && !done_reg[cur] && !d_exp[TIME_BITS-1];
                if (d_ord != '0)
                begin
                    better = d_ord[TIME_BITS-1];
                end
                else
                begin
                    better = r_id < bid_reg;
                end
                better = cand && (!found_reg || better);
            end
            default:
            begin
                cand = valid_reg[cur] && (r_id == item_reg.target_id);
                better = cand && !found_reg;
            end
        endcase
    end

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cur;
        ram_wdata = {bid_reg, bdl_reg + bper_reg, bper_reg};
        if (state_reg == S_IDLE && in_valid && in_ready && in_data.opcode == OP_START)
        begin
            ram_we    = any_free;
            ram_addr  = free_slot;
            ram_wdata = {nid_reg, TIME_BITS'(now_reg + TIME_BITS'(in_data.delay_ticks)),
                         TIME_BITS'(in_data.period_ticks)};
        end
        else if (state_reg == S_WB)
        begin
            ram_we   = 1'b1;
            ram_addr = best_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            nid_reg   <= '0;
            valid_reg <= '0;
            done_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            nfire_reg <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg  <= in_data;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        done_reg  <= '0;
                        nfire_reg <= '0;
                        pend_reg  <= 1'b0;
                        if (in_data.opcode == OP_START)
                        begin
                            out_reg.reply_kind  <= RK_START;
                            out_reg.last_of_run <= 1'b1;
                            ov_reg <= 1'b1;
                            if (any_free)
                            begin
                                valid_reg[free_slot] <= 1'b1;
                                nid_reg <= nid_reg + 1'b1;
                                out_reg.reply_id <= nid_reg;
                                out_reg.status   <= ST_OK;
                            end
                            else
                            begin
                                out_reg.reply_id <= '0;
                                out_reg.status   <= ST_FULL;
                            end
                        end
                        else
                        begin
                            if (in_data.opcode == OP_TICK)
                            begin
                                now_reg <= now_reg + 1'b1;
                            end
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (better)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= cur;
                        bid_reg   <= r_id;
                        bdl_reg   <= r_dl;
                        bper_reg  <= r_per;
                    end
                    if (idx_reg == CB'(NUM_TIMERS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    if (item_reg.opcode == OP_TICK)
                    begin
                        if (found_reg && nfire_reg != NB'(MAX_RESULTS))
                        begin
                            // emit the previous fire, hold this one
                            if (pend_reg)
                            begin
                                out_reg <= pout_reg;
                                ov_reg  <= 1'b1;
                            end
                            pend_reg <= 1'b1;
                            pout_reg <= '{RK_FIRED, bid_reg, ST_OK, 1'b0};
                            nfire_reg <= nfire_reg + 1'b1;
                            done_reg[best_reg] <= 1'b1;
                            if (bper_reg == '0)
                            begin
                                valid_reg[best_reg] <= 1'b0;
                            end
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            if (pend_reg)
                            begin
                                out_reg <= '{RK_FIRED, pout_reg.reply_id, ST_OK, 1'b1};
                                ov_reg  <= 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        out_reg.reply_kind  <= (item_reg.opcode == OP_STOP) ? RK_STOP : RK_QUERY;
                        out_reg.reply_id    <= item_reg.target_id;
                        out_reg.status      <= found_reg ? ST_OK : ST_NOTFOUND;
                        out_reg.last_of_run <= 1'b1;
                        ov_reg <= 1'b1;
                        if (found_reg && item_reg.opcode == OP_STOP)
                        begin
                            valid_reg[best_reg] <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_WB:
                begin
                    // wait for the fired item to drain before the next scan
                    if (!ov_reg || out_ready)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/mtq_ram.sv
// ----------------------------------------------------------------------------
// mtq_ram: generic single-port ram
// one access per cycle, a write also reads the old word, registered read data
// ----------------------------------------------------------------------------
module mtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/mtq_checker.sv
// ----------------------------------------------------------------------------
// mtq_checker: port-level checks of the timer queue
// handshake and reply consistency, bound to the top level
// ----------------------------------------------------------------------------
module mtq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input mtq_pkg::mtq_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input mtq_pkg::mtq_out_t out_data
);
    import mtq_pkg::*;

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // no new input while a reply waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a reply waits");

    // fired items carry ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reply_kind == RK_FIRED |-> out_data.status == ST_OK)
        else $error("fired item with bad status");

    // non-tick replies end their run
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reply_kind != RK_FIRED |-> out_data.last_of_run)
        else $error("single reply not marked last");

endmodule

bind multi_timer_queue_unit mtq_checker u_mtq_checker (.*);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: multi timer queue unit
// drives start, stop, tick and query items with random idling on both sides,
// predicts every reply with a behavioral timer table and checks each reply
// field by field in order
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mtq_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;

    // behavioral timer table and reply checker
    class timer_table_sb;
        logic [31:0] now_cnt;
        logic [31:0] id_cnt;
        bit          used [NT];
        logic [31:0] tid [NT];
        logic [31:0] dl [NT];
        logic [31:0] per [NT];
        mtq_out_t    pending [$];
        int          errors;

        function new();
            now_cnt = 0;
            id_cnt = 0;
            errors = 0;
            for (int s = 0; s < NT; s++)
            begin
                used[s] = 0;
                tid[s] = 0;
                dl[s] = 0;
                per[s] = 0;
            end
        endfunction

        function void push_reply(logic [1:0] k, logic [31:0] id, logic [1:0] st,
                                 logic lst);
            mtq_out_t r;
            r.reply_kind = k;
            r.reply_id = id;
            r.status = st;
            r.last_of_run = lst;
            pending.push_back(r);
        endfunction

        function int lookup(logic [31:0] id);
            for (int s = 0; s < NT; s++)
                if (used[s] && tid[s] == id)
                    return s;
            return -1;
        endfunction

        function bit fires_before(int a, int b);
            logic [31:0] d;
            d = dl[a] - dl[b];
            if (d != 0)
                return d[31];
            return tid[a] < tid[b];
        endfunction

        // note an accepted item and queue its replies
        function void note_item(mtq_in_t it);
            int s;
            int n;
            int best;
            bit due [NT];
            logic [31:0] d;
            case (it.opcode)
                OP_START:
                begin
                    s = -1;
                    for (int i = NT - 1; i >= 0; i--)
                        if (!used[i])
                            s = i;
                    if (s < 0)
                        push_reply(RK_START, 0, ST_FULL, 1);
                    else
                    begin
                        used[s] = 1;
                        tid[s] = id_cnt;
                        dl[s] = now_cnt + it.delay_ticks;
                        per[s] = it.period_ticks;
                        id_cnt = id_cnt + 1;
                        push_reply(RK_START, tid[s], ST_OK, 1);
                    end
                end
                OP_STOP:
                begin
                    s = lookup(it.target_id);
                    if (s < 0)
                        push_reply(RK_STOP, it.target_id, ST_NOTFOUND, 1);
                    else
                    begin
                        used[s] = 0;
                        push_reply(RK_STOP, it.target_id, ST_OK, 1);
                    end
                end
                OP_QUERY:
                    push_reply(RK_QUERY, it.target_id,
                               (lookup(it.target_id) >= 0) ? ST_OK : ST_NOTFOUND, 1);
                default:
                begin
                    now_cnt = now_cnt + 1;
                    for (int i = 0; i < NT; i++)
                    begin
                        d = now_cnt - dl[i];
                        due[i] = used[i] && !d[31];
                    end
                    n = 0;
                    while (n < MAX_RESULTS)
                    begin
                        best = -1;
                        for (int i = 0; i < NT; i++)
                            if (due[i] && (best < 0 || fires_before(i, best)))
                                best = i;
                        if (best < 0)
                            break;
                        due[best] = 0;
                        push_reply(RK_FIRED, tid[best], ST_OK, 0);
                        n++;
                        if (per[best] != 0)
                            dl[best] = dl[best] + per[best];
                        else
                            used[best] = 0;
                    end
                    if (n > 0)
                        pending[$].last_of_run = 1;
                end
            endcase
        endfunction

        // compare one reply against the oldest expectation
        function void check_reply(mtq_out_t got);
            mtq_out_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected reply kind=%0d id=%0h", got.reply_kind, got.reply_id);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.reply_kind !== exp_r.reply_kind)
            begin
                $error("reply_kind expected %0d actual %0d", exp_r.reply_kind, got.reply_kind);
                errors++;
            end
            if (got.reply_id !== exp_r.reply_id)
            begin
                $error("reply_id expected %0h actual %0h", exp_r.reply_id, got.reply_id);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $error("status expected %0d actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.last_of_run !== exp_r.last_of_run)
            begin
                $error("last_of_run expected %0d actual %0d", exp_r.last_of_run,
                       got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mtq_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mtq_out_t out_data;

    timer_table_sb sb;
    bit            no_idle;
    bit            hold_off;
    int            cycles;
    int            sent;

    multi_timer_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // send one item, optionally after an idle burst
    task automatic send_item(logic [1:0] op, logic [31:0] dly, logic [31:0] per,
                             logic [31:0] id);
        mtq_in_t it;
        it.opcode = op;
        it.delay_ticks = dly;
        it.period_ticks = per;
        it.target_id = id;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        sent++;
    endtask

    // pick an id near the allocated range, now and then a random one
    function automatic logic [31:0] near_id();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return sb.id_cnt - $urandom_range(0, 20);
    endfunction

    // receiver with random stalls and one long hold-off
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_reply(out_data);
            if (hold_off)
                out_ready <= 0;
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 11))
                begin
                    @(posedge clk);
                    if (out_valid && out_ready)
                        sb.check_reply(out_data);
                end
                out_ready <= 1;
            end
            else
                out_ready <= 1;
        end
    end

    // long hold-off on the reply side, counted here
    initial
    begin
        hold_off = 0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_off <= 1;
        repeat (800) @(posedge clk);
        hold_off <= 0;
    end

    // stimulus
    initial
    begin
        int k;
        int r;
        sb = new();
        no_idle = 0;
        sent = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: quiet tick, empty lookups, field extremes
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF);
        send_item(OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(OP_START, 0, 0, 0);
        send_item(OP_START, 1, 3, 32'hFFFF_FFFF);
        send_item(OP_START, 32'hFFFF_FFFF, 0, 0);
        send_item(OP_START, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_item(OP_QUERY, 0, 0, 1);
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0);
        // ties on the same deadline and a full table
        for (int i = 0; i < 14; i++)
            send_item(OP_START, 2, (i % 2) ? 1 : 0, 0);
        send_item(OP_START, 5, 5, 0);
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_STOP, 0, 0, 1);

        // random part: mostly starts, ticks and lookups on live ids
        for (int n = 0; n < 260; n++)
        begin
            if (n == 230)
                no_idle = 1;
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                k = $urandom_range(0, 9);
                send_item(OP_START,
                          (k == 0) ? $urandom : $urandom_range(0, 6),
                          (k == 1) ? $urandom : (k < 5 ? 0 : $urandom_range(0, 4)),
                          $urandom);
            end
            else if (r < 65)
                send_item(OP_TICK, $urandom, $urandom, $urandom);
            else if (r < 82)
                send_item(OP_STOP, $urandom, $urandom, near_id());
            else
                send_item(OP_QUERY, $urandom, $urandom, near_id());
        end
        in_valid <= 0;

        // drain, then let any trailing scan finish
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
